@@ design/fdmc_pkg.sv @@
// Shared types and constants for the frame-difference motion centroid core.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package fdmc_pkg;

    // Frame geometry and centroid window
    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;
    localparam int EDGE_MARGIN  = 6;

    // Field and accumulator widths
    localparam int PIX_W  = 8;
    localparam int COL_W  = 10;
    localparam int ROW_W  = 9;
    localparam int SUMX_W = 30;
    localparam int SUMY_W = 29;
    localparam int HIT_W  = 20;
    localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

    // Stream and configuration port widths
    localparam int IN_DATA_W  = 6 * PIX_W;
    localparam int OUT_DATA_W = 6 * PIX_W + COL_W + ROW_W + HIT_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Divider iteration counter
    localparam int DIV_CNT_W = $clog2(SUMX_W);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MARK      = 2'd2;

    // Mode codes; the unused codes behave like pass
    localparam logic [2:0] MODE_PASS   = 3'd0;
    localparam logic [2:0] MODE_COPY   = 3'd1;
    localparam logic [2:0] MODE_ABS    = 3'd2;
    localparam logic [2:0] MODE_SWAP   = 3'd3;
    localparam logic [2:0] MODE_THRESH = 3'd4;

    // Register reset values
    localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd40;
    localparam logic [PIX_W-1:0] MARK_RESET      = 8'd70;

    typedef logic [2:0][PIX_W-1:0] rgb_t;

    // One queue entry: a processed pixel, plus the frame totals on the last pixel
    typedef struct packed {
        rgb_t              store_pix;
        rgb_t              out_pix;
        logic              frame_end;
        logic [SUMX_W-1:0] sum_x;
        logic [SUMY_W-1:0] sum_y;
        logic [HIT_W-1:0]  hits;
    } fdmc_item_t;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [SUMX_W-1:0] sum_x;
        logic [SUMY_W-1:0] sum_y;
        logic [HIT_W-1:0]  hits;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [SUMX_W-1:0] quo_x;
        logic [SUMX_W-1:0] quo_y;
    } div_rsp_t;

    // Back-end sequencer states
    typedef enum logic {
        BACK_RUN,
        BACK_DIV
    } back_state_t;

endpackage

@@ design/frame_difference_motion_centroid_core.sv @@
// Top level of the frame-difference motion centroid core.
// Instantiates fdmc_front, fdmc_queue, fdmc_div and fdmc_back; uses fdmc_pkg.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: current and previous RGB pixel
//  m_      | out | m_tvalid/m_tready  | m_tdata, m_tuser (summary flag), m_tlast
//  cfg_    | in  | cfg_we             | cfg_index, cfg_data
//
// A pixel is processed in the cycle it is accepted and enters the queue at its input
// transfer; it moves from the queue head to the output register when that register is
// free, and leaves from there at the output transfer. The last pixel of a frame starts
// a shift-and-subtract divider; the summary result is loaded once the divider is done
// and the output register is free, and a four-entry queue keeps taking pixels until it
// fills. Reset clears counters, sums, queue and output valid, and sets the registers to
// mode 0, threshold 40, mark 70. Either side may stall at any time.
`timescale 1ns / 1ps

module frame_difference_motion_centroid_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fdmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fdmc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cur_red, cur_green, cur_blue, prev_red, prev_green, prev_blue
    input  logic [fdmc_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_red, out_green, out_blue, store_red, store_green, store_blue,
    // centre_x, centre_y, hit_total, centre_inside
    output logic [fdmc_pkg::OUT_DATA_W-1:0] m_tdata,
    // is_summary
    output logic [0:0]                      m_tuser,
    output logic                            m_tlast
);

    fdmc_pkg::fdmc_item_t q_item;
    fdmc_pkg::fdmc_item_t q_head;
    fdmc_pkg::div_req_t   div_req;
    fdmc_pkg::div_rsp_t   div_rsp;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;

    fdmc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    fdmc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    fdmc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    fdmc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // A summary result always closes its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("summary result without last flag");

    // The queue is never written while full nor read while empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    // A new division never starts while one is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

endmodule

@@ design/fdmc_front.sv @@
// Front part: configuration registers, pixel processing, position counters
// and hit accumulation. Depends on fdmc_pkg.
`timescale 1ns / 1ps

module fdmc_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fdmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fdmc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fdmc_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            q_full,
    output logic                            q_push,
    output fdmc_pkg::fdmc_item_t            q_item
);

    logic [2:0]                       mode_reg;
    logic [fdmc_pkg::PIX_W-1:0]       thr_reg;
    logic [fdmc_pkg::PIX_W-1:0]       mark_reg;
    logic [fdmc_pkg::COL_W-1:0]       col_reg;
    logic [fdmc_pkg::COL_W-1:0]       col_next;
    logic [fdmc_pkg::ROW_W-1:0]       row_reg;
    logic [fdmc_pkg::ROW_W-1:0]       row_next;
    logic [fdmc_pkg::SUMX_W-1:0]      sum_x_reg;
    logic [fdmc_pkg::SUMX_W-1:0]      sum_x_next;
    logic [fdmc_pkg::SUMY_W-1:0]      sum_y_reg;
    logic [fdmc_pkg::SUMY_W-1:0]      sum_y_next;
    logic [fdmc_pkg::HIT_W-1:0]       hit_reg;
    logic [fdmc_pkg::HIT_W-1:0]       hit_next;
    fdmc_pkg::rgb_t                   cur;
    fdmc_pkg::rgb_t                   prev;
    fdmc_pkg::rgb_t                   dif;
    fdmc_pkg::rgb_t                   res;
    fdmc_pkg::rgb_t                   sto;
    logic [2:0]                       hit;
    logic [1:0]                       hit_cnt;
    logic [fdmc_pkg::HIT_W-1:0]       room;
    logic [1:0]                       eff;
    logic [fdmc_pkg::SUMX_W-1:0]      add_x;
    logic [fdmc_pkg::SUMY_W-1:0]      add_y;
    logic                             end_row;
    logic                             end_frame;
    logic                             accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    // Configuration writes; indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= fdmc_pkg::MODE_PASS;
            thr_reg  <= fdmc_pkg::THRESHOLD_RESET;
            mark_reg <= fdmc_pkg::MARK_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == fdmc_pkg::REG_MODE)
                mode_reg <= cfg_data[2:0];
            if (cfg_index == fdmc_pkg::REG_THRESHOLD)
                thr_reg <= cfg_data;
            if (cfg_index == fdmc_pkg::REG_MARK)
                mark_reg <= cfg_data;
        end
    end

    // Per-channel difference and mode selection
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            cur[c]  = s_tdata[fdmc_pkg::PIX_W*c +: fdmc_pkg::PIX_W];
            prev[c] = s_tdata[fdmc_pkg::PIX_W*(c+3) +: fdmc_pkg::PIX_W];
            dif[c]  = (cur[c] >= prev[c]) ? (cur[c] - prev[c]) : (prev[c] - cur[c]);
            hit[c]  = 1'b0;
            unique case (mode_reg)
                fdmc_pkg::MODE_COPY:
                begin
                    res[c] = cur[c];
                    sto[c] = cur[c];
                end
                fdmc_pkg::MODE_ABS:
                begin
                    res[c] = dif[c];
                    sto[c] = prev[c];
                end
                fdmc_pkg::MODE_SWAP:
                begin
                    res[c] = dif[c];
                    sto[c] = cur[c];
                end
                fdmc_pkg::MODE_THRESH:
                begin
                    hit[c] = dif[c] > thr_reg;
                    res[c] = hit[c] ? mark_reg : '0;
                    sto[c] = cur[c];
                end
                default:
                begin
                    res[c] = cur[c];
                    sto[c] = prev[c];
                end
            endcase
        end
    end

    // Hits that still fit up to the counter's full value
    always_comb
    begin
        hit_cnt = {1'b0, hit[0]} + {1'b0, hit[1]} + {1'b0, hit[2]};
        room    = fdmc_pkg::HIT_MAX - hit_reg;
        eff     = (room < fdmc_pkg::HIT_W'(hit_cnt)) ? room[1:0] : hit_cnt;
        unique case (eff)
            2'd0:
            begin
                add_x = '0;
                add_y = '0;
            end
            2'd1:
            begin
                add_x = fdmc_pkg::SUMX_W'(col_reg);
                add_y = fdmc_pkg::SUMY_W'(row_reg);
            end
            2'd2:
            begin
                add_x = fdmc_pkg::SUMX_W'({col_reg, 1'b0});
                add_y = fdmc_pkg::SUMY_W'({row_reg, 1'b0});
            end
            default:
            begin
                add_x = fdmc_pkg::SUMX_W'({col_reg, 1'b0}) + fdmc_pkg::SUMX_W'(col_reg);
                add_y = fdmc_pkg::SUMY_W'({row_reg, 1'b0}) + fdmc_pkg::SUMY_W'(row_reg);
            end
        endcase
        sum_x_next = sum_x_reg + add_x;
        sum_y_next = sum_y_reg + add_y;
        hit_next   = hit_reg + fdmc_pkg::HIT_W'(eff);
    end

    // Raster position
    always_comb
    begin
        end_row   = col_reg >= fdmc_pkg::COL_W'(fdmc_pkg::FRAME_WIDTH - 1);
        end_frame = end_row && (row_reg >= fdmc_pkg::ROW_W'(fdmc_pkg::FRAME_HEIGHT - 1));
        if (end_row)
        begin
            col_next = '0;
            row_next = end_frame ? '0 : row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    // Queue entry for the accepted pixel
    always_comb
    begin
        q_item.out_pix   = res;
        q_item.store_pix = sto;
        q_item.frame_end = end_frame;
        q_item.sum_x     = sum_x_next;
        q_item.sum_y     = sum_y_next;
        q_item.hits      = hit_next;
    end

    // Position and accumulator state; totals clear after the frame's last pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            hit_reg   <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (end_frame)
            begin
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                hit_reg   <= '0;
            end
            else
            begin
                sum_x_reg <= sum_x_next;
                sum_y_reg <= sum_y_next;
                hit_reg   <= hit_next;
            end
        end
    end

endmodule

@@ design/fdmc_queue.sv @@
// Short FIFO that decouples the pixel front from the result back.
// Depends on fdmc_pkg for the entry type and depth.
`timescale 1ns / 1ps

module fdmc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  fdmc_pkg::fdmc_item_t push_item,
    input  logic                 pop,
    output fdmc_pkg::fdmc_item_t head,
    output logic                 full,
    output logic                 empty
);

    fdmc_pkg::fdmc_item_t             mem_reg [fdmc_pkg::Q_DEPTH];
    logic [fdmc_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [fdmc_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [fdmc_pkg::Q_CNT_W-1:0]     count_reg;
    logic [fdmc_pkg::Q_CNT_W-1:0]     count_next;

    assign full  = count_reg == fdmc_pkg::Q_CNT_W'(fdmc_pkg::Q_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

@@ design/fdmc_div.sv @@
// Restoring divider, one quotient bit per cycle, two lanes sharing one counter:
// column sum and row sum over the hit count. Depends on fdmc_pkg.
`timescale 1ns / 1ps

module fdmc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  fdmc_pkg::div_req_t req,
    output fdmc_pkg::div_rsp_t rsp
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [fdmc_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [fdmc_pkg::HIT_W-1:0]       dvs_reg;
    logic [fdmc_pkg::SUMX_W-1:0]      dq_x_reg;
    logic [fdmc_pkg::SUMX_W-1:0]      dq_x_next;
    logic [fdmc_pkg::SUMX_W-1:0]      dq_y_reg;
    logic [fdmc_pkg::SUMX_W-1:0]      dq_y_next;
    logic [fdmc_pkg::HIT_W-1:0]       rem_x_reg;
    logic [fdmc_pkg::HIT_W-1:0]       rem_x_next;
    logic [fdmc_pkg::HIT_W-1:0]       rem_y_reg;
    logic [fdmc_pkg::HIT_W-1:0]       rem_y_next;
    logic [fdmc_pkg::HIT_W:0]         sh_x;
    logic [fdmc_pkg::HIT_W:0]         sh_y;
    logic                             bit_x;
    logic                             bit_y;
    logic                             last_step;

    // One shift-and-subtract step per lane
    always_comb
    begin
        sh_x       = {rem_x_reg, dq_x_reg[fdmc_pkg::SUMX_W-1]};
        sh_y       = {rem_y_reg, dq_y_reg[fdmc_pkg::SUMX_W-1]};
        bit_x      = sh_x >= {1'b0, dvs_reg};
        bit_y      = sh_y >= {1'b0, dvs_reg};
        rem_x_next = bit_x ? fdmc_pkg::HIT_W'(sh_x - {1'b0, dvs_reg})
                           : fdmc_pkg::HIT_W'(sh_x);
        rem_y_next = bit_y ? fdmc_pkg::HIT_W'(sh_y - {1'b0, dvs_reg})
                           : fdmc_pkg::HIT_W'(sh_y);
        dq_x_next  = {dq_x_reg[fdmc_pkg::SUMX_W-2:0], bit_x};
        dq_y_next  = {dq_y_reg[fdmc_pkg::SUMX_W-2:0], bit_y};
        last_step  = cnt_reg == fdmc_pkg::DIV_CNT_W'(fdmc_pkg::SUMX_W - 1);
    end

    // A zero hit count gives a zero centroid
    always_comb
    begin
        rsp.busy  = busy_reg;
        rsp.done  = done_reg;
        rsp.quo_x = (dvs_reg == '0) ? '0 : dq_x_reg;
        rsp.quo_y = (dvs_reg == '0) ? '0 : dq_y_reg;
    end

    // Operand and quotient registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvs_reg   <= req.hits;
            dq_x_reg  <= req.sum_x;
            dq_y_reg  <= fdmc_pkg::SUMX_W'(req.sum_y);
            rem_x_reg <= '0;
            rem_y_reg <= '0;
        end
        else if (busy_reg)
        begin
            dq_x_reg  <= dq_x_next;
            dq_y_reg  <= dq_y_next;
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
        end
    end

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

@@ design/fdmc_back.sv @@
// Back part: drains the queue into the output register and sequences the
// end-of-frame centroid through the divider. Depends on fdmc_pkg.
`timescale 1ns / 1ps

module fdmc_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fdmc_pkg::fdmc_item_t            head,
    input  logic                            q_empty,
    output logic                            q_pop,
    output fdmc_pkg::div_req_t              div_req,
    input  fdmc_pkg::div_rsp_t              div_rsp,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fdmc_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [0:0]                      m_tuser,
    output logic                            m_tlast
);

    fdmc_pkg::back_state_t            state_reg;
    fdmc_pkg::back_state_t            state_next;
    logic                             out_valid_reg;
    logic [fdmc_pkg::OUT_DATA_W-1:0]  out_data_reg;
    logic [fdmc_pkg::OUT_DATA_W-1:0]  sum_data;
    logic                             out_summary_reg;
    logic                             out_last_reg;
    logic [fdmc_pkg::HIT_W-1:0]       hits_reg;
    logic                             slot_free;
    logic                             load_pix;
    logic                             load_sum;
    logic                             centre_in;

    assign slot_free = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_summary_reg;
    assign m_tlast   = out_last_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fdmc_pkg::BACK_RUN:
                if (!q_empty && slot_free && head.frame_end)
                    state_next = fdmc_pkg::BACK_DIV;
            fdmc_pkg::BACK_DIV:
                if (div_rsp.done && slot_free)
                    state_next = fdmc_pkg::BACK_RUN;
            default:
                state_next = fdmc_pkg::BACK_RUN;
        endcase
    end

    // Control outputs
    always_comb
    begin
        load_pix = 1'b0;
        load_sum = 1'b0;
        unique case (state_reg)
            fdmc_pkg::BACK_RUN:
                load_pix = !q_empty && slot_free;
            fdmc_pkg::BACK_DIV:
                load_sum = div_rsp.done && slot_free;
            default:
            begin
                load_pix = 1'b0;
                load_sum = 1'b0;
            end
        endcase
        q_pop         = load_pix;
        div_req.start = load_pix && head.frame_end;
        div_req.sum_x = head.sum_x;
        div_req.sum_y = head.sum_y;
        div_req.hits  = head.hits;
    end

    // Summary fields from the quotients
    always_comb
    begin
        centre_in = (div_rsp.quo_x >= fdmc_pkg::SUMX_W'(fdmc_pkg::EDGE_MARGIN))
                 && (div_rsp.quo_x <= fdmc_pkg::SUMX_W'(fdmc_pkg::FRAME_WIDTH
                                                        - fdmc_pkg::EDGE_MARGIN))
                 && (div_rsp.quo_y >= fdmc_pkg::SUMX_W'(fdmc_pkg::EDGE_MARGIN))
                 && (div_rsp.quo_y <= fdmc_pkg::SUMX_W'(fdmc_pkg::FRAME_HEIGHT
                                                        - fdmc_pkg::EDGE_MARGIN));
        sum_data = {centre_in, hits_reg,
                    div_rsp.quo_y[fdmc_pkg::ROW_W-1:0],
                    div_rsp.quo_x[fdmc_pkg::COL_W-1:0],
                    {(6 * fdmc_pkg::PIX_W){1'b0}}};
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (load_pix)
        begin
            out_data_reg    <= {{(fdmc_pkg::OUT_DATA_W - 6 * fdmc_pkg::PIX_W){1'b0}},
                                head.store_pix, head.out_pix};
            out_summary_reg <= 1'b0;
            out_last_reg    <= !head.frame_end;
            hits_reg        <= head.hits;
        end
        else if (load_sum)
        begin
            out_data_reg    <= sum_data;
            out_summary_reg <= 1'b1;
            out_last_reg    <= 1'b1;
        end
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fdmc_pkg::BACK_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_pix || load_sum)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule
